// ===== src/morse_code_decoder_top_assert.svh =====
// Assertion macros for the Morse code decoder checker.
// Depends on a clk_i and an rst_ni signal in the scope that uses them.
`ifndef MORSE_CODE_DECODER_TOP_ASSERT_SVH
`define MORSE_CODE_DECODER_TOP_ASSERT_SVH

// Implication that must hold in the same cycle, checked outside reset.
`define MCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Implication whose consequence must hold in the next cycle, checked outside reset.
`define MCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mcd_pkg.sv =====
// Shared constants, types and the Morse code table of the decoder.
// No dependencies.
package mcd_pkg;

  localparam int unsigned MaxLen = 6;
  localparam int unsigned LenW   = 3;
  localparam int unsigned CharW  = 7;

  // Input byte codes.
  localparam logic [7:0] SymDot   = 8'h2E;
  localparam logic [7:0] SymDash  = 8'h2D;
  localparam logic [7:0] SymSlash = 8'h2F;
  localparam logic [7:0] SymSpace = 8'h20;
  localparam logic [7:0] SymTab   = 8'h09;
  localparam logic [7:0] SymCr    = 8'h0D;

  localparam logic [CharW-1:0] ChSpace = 7'h20;

  // Result of flushing a token.
  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] ch;
  } mcd_flush_t;

  // Table lookup: bit i of pat is a dash at position i. Codes never collide.
  function automatic mcd_flush_t mcd_lookup(input logic [LenW-1:0] len,
                                            input logic [MaxLen-1:0] pat);
    mcd_flush_t r;
    r.hit = 1'b1;
    r.ch  = '0;
    unique case ({len, pat})
      {3'd2, 6'b000010}: r.ch = 7'h41; // A
      {3'd4, 6'b000001}: r.ch = 7'h42; // B
      {3'd4, 6'b000101}: r.ch = 7'h43; // C
      {3'd3, 6'b000001}: r.ch = 7'h44; // D
      {3'd1, 6'b000000}: r.ch = 7'h45; // E
      {3'd4, 6'b000100}: r.ch = 7'h46; // F
      {3'd3, 6'b000011}: r.ch = 7'h47; // G
      {3'd4, 6'b000000}: r.ch = 7'h48; // H
      {3'd2, 6'b000000}: r.ch = 7'h49; // I
      {3'd4, 6'b001110}: r.ch = 7'h4A; // J
      {3'd3, 6'b000101}: r.ch = 7'h4B; // K
      {3'd4, 6'b000010}: r.ch = 7'h4C; // L
      {3'd2, 6'b000011}: r.ch = 7'h4D; // M
      {3'd2, 6'b000001}: r.ch = 7'h4E; // N
      {3'd3, 6'b000111}: r.ch = 7'h4F; // O
      {3'd4, 6'b000110}: r.ch = 7'h50; // P
      {3'd4, 6'b001011}: r.ch = 7'h51; // Q
      {3'd3, 6'b000010}: r.ch = 7'h52; // R
      {3'd3, 6'b000000}: r.ch = 7'h53; // S
      {3'd1, 6'b000001}: r.ch = 7'h54; // T
      {3'd3, 6'b000100}: r.ch = 7'h55; // U
      {3'd4, 6'b001000}: r.ch = 7'h56; // V
      {3'd3, 6'b000110}: r.ch = 7'h57; // W
      {3'd4, 6'b001001}: r.ch = 7'h58; // X
      {3'd4, 6'b001101}: r.ch = 7'h59; // Y
      {3'd4, 6'b000011}: r.ch = 7'h5A; // Z
      {3'd5, 6'b011111}: r.ch = 7'h30; // 0
      {3'd5, 6'b011110}: r.ch = 7'h31; // 1
      {3'd5, 6'b011100}: r.ch = 7'h32; // 2
      {3'd5, 6'b011000}: r.ch = 7'h33; // 3
      {3'd5, 6'b010000}: r.ch = 7'h34; // 4
      {3'd5, 6'b000000}: r.ch = 7'h35; // 5
      {3'd5, 6'b000001}: r.ch = 7'h36; // 6
      {3'd5, 6'b000011}: r.ch = 7'h37; // 7
      {3'd5, 6'b000111}: r.ch = 7'h38; // 8
      {3'd5, 6'b001111}: r.ch = 7'h39; // 9
      {3'd5, 6'b001001}: r.ch = 7'h2F; // slash
      {3'd6, 6'b001100}: r.ch = 7'h3F; // question mark
      {3'd6, 6'b101010}: r.ch = 7'h2E; // period
      {3'd6, 6'b110011}: r.ch = 7'h2C; // comma
      {3'd5, 6'b001010}: r.ch = 7'h2B; // plus
      {3'd5, 6'b010001}: r.ch = 7'h3D; // equals
      default:           r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/mcd_if.sv =====
// Valid/ready channel interfaces for the Morse code decoder.
// Depends on mcd_pkg.

interface mcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_char;
  logic       end_of_text;

  modport source (output valid, output symbol_char, output end_of_text, input ready);
  modport sink   (input valid, input symbol_char, input end_of_text, output ready);
  modport mon    (input valid, input symbol_char, input end_of_text, input ready);
endinterface

interface mcd_out_if;
  logic                      valid;
  logic                      ready;
  logic [mcd_pkg::CharW-1:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
  modport mon    (input valid, input text_char, input ready);
endinterface

// ===== src/morse_code_decoder_top.sv =====
// Top level of the Morse code decoder: input channel, token logic, result register.
// Depends on mcd_pkg, mcd_if.sv and mcd_token.
//
//   channel  | direction | payload                     | beat
//   in_i     | sink      | symbol_char, end_of_text    | one Morse text byte
//   out_o    | source    | text_char                   | one decoded character
//
// Every beat is taken in and decoded in the cycle it is accepted; a decoded
// character shows on out_o in the next cycle. One beat per cycle is sustained while out_o takes its results.
// The only stored path is the token register set and the result register.
// Reset (rst_ni low, asynchronous) clears the pending token and the result valid.
// in_i stalls only while a result sits in out_o and is not being taken.
module morse_code_decoder_top (
  input logic      clk_i,
  input logic      rst_ni,
  mcd_in_if.sink   in_i,
  mcd_out_if.source out_o
);
  import mcd_pkg::*;

  logic             accept;
  mcd_flush_t       flush;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] text_char_q;

  // The result register frees up in the same cycle it is read, so the input
  // waits only while the output is stalled.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  mcd_token u_token (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .symbol_char_i (in_i.symbol_char),
    .end_of_text_i (in_i.end_of_text),
    .flush_o       (flush)
  );

  // A beat that decodes to a character loads the register; otherwise a taken
  // result leaves it empty.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = flush.hit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && flush.hit) begin
      text_char_q <= flush.ch;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.text_char = text_char_q;

endmodule

// ===== src/mcd_token.sv =====
// Token gathering and flush decode for the Morse code decoder.
// Depends on mcd_pkg.
module mcd_token (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          symbol_char_i,
  input  logic                end_of_text_i,
  output mcd_pkg::mcd_flush_t flush_o
);
  import mcd_pkg::*;

  logic [LenW-1:0]   len_q, len_d, len_u;
  logic [MaxLen-1:0] pat_q, pat_d, pat_u;
  logic              mal_q, mal_d, mal_u;
  logic              sls_q, sls_d, sls_u;
  logic              is_sep;
  mcd_flush_t        flush_cur, flush_upd;

  assign is_sep = (symbol_char_i == SymSpace) ||
                  ((symbol_char_i >= SymTab) && (symbol_char_i <= SymCr));

  // Token after taking in a non-separator byte.
  always_comb begin
    len_u = len_q;
    pat_u = pat_q;
    mal_u = mal_q;
    sls_u = sls_q;
    if ((symbol_char_i == SymDot) || (symbol_char_i == SymDash)) begin
      if (sls_q || (len_q >= LenW'(MaxLen))) begin
        mal_u = 1'b1;
      end else begin
        pat_u[len_q] = (symbol_char_i == SymDash);
        len_u        = len_q + 1'b1;
      end
    end else if (symbol_char_i == SymSlash) begin
      if ((len_q == '0) && !sls_q && !mal_q) begin
        sls_u = 1'b1;
      end else begin
        mal_u = 1'b1;
      end
    end else begin
      mal_u = 1'b1;
    end
  end

  function automatic mcd_flush_t flush_of(input logic [LenW-1:0] len,
                                          input logic [MaxLen-1:0] pat,
                                          input logic mal, input logic sls);
    mcd_flush_t r;
    r = mcd_lookup(len, pat);
    if (sls) begin
      r.hit = 1'b1;
      r.ch  = ChSpace;
    end
    if (mal || (!sls && (len == '0))) begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  assign flush_cur = flush_of(len_q, pat_q, mal_q, sls_q);
  assign flush_upd = flush_of(len_u, pat_u, mal_u, sls_u);

  always_comb begin
    flush_o = '0;
    len_d   = len_u;
    pat_d   = pat_u;
    mal_d   = mal_u;
    sls_d   = sls_u;
    if (is_sep || end_of_text_i) begin
      flush_o = is_sep ? flush_cur : flush_upd;
      len_d   = '0;
      pat_d   = '0;
      mal_d   = 1'b0;
      sls_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pat_q <= '0;
      mal_q <= 1'b0;
      sls_q <= 1'b0;
    end else if (accept_i) begin
      len_q <= len_d;
      pat_q <= pat_d;
      mal_q <= mal_d;
      sls_q <= sls_d;
    end
  end

endmodule

// ===== src/mcd_checker.sv =====
// Port-level checks for the Morse code decoder, bound to its top level.
// Depends on mcd_pkg, mcd_if.sv and morse_code_decoder_top_assert.svh.
`include "morse_code_decoder_top_assert.svh"

module mcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  mcd_in_if.sink    in_i,
  mcd_out_if.source out_o
);
  import mcd_pkg::*;

  logic in_acc;
  logic out_stall;
  logic sym_only;

  assign in_acc    = in_i.valid && in_i.ready;
  assign out_stall = out_o.valid && !out_o.ready;
  assign sym_only  = (in_i.symbol_char == SymDot) || (in_i.symbol_char == SymDash) ||
                     (in_i.symbol_char == SymSlash);

  // A stalled result holds.
  `MCD_ASSERT_NEXT(a_out_hold, out_stall, out_o.valid && $stable(out_o.text_char), "stalled result changed")

  // The input is only held off by a stalled result.
  `MCD_ASSERT_NOW(a_in_ready, !out_stall, in_i.ready, "input stalled without a stalled result")

  // A new result follows an accepted beat.
  `MCD_ASSERT_NOW(a_out_cause, $rose(out_o.valid), $past(in_acc), "result without an input beat")

  // A dot, dash or slash that does not end the text decodes to nothing.
  `MCD_ASSERT_NEXT(a_no_early, in_acc && sym_only && !in_i.end_of_text && !out_stall, !out_o.valid, "result from a byte inside a token")

endmodule

bind morse_code_decoder_top mcd_checker u_mcd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

// ===== sim/morse_code_decoder_top_tb.sv =====
// Self-checking testbench for morse_code_decoder_top: a directed stimulus table, then random
// Morse text, with every decoded character checked against a predictor in this file or a typed table value.
// Depends on mcd_pkg, mcd_if.sv and the decoder RTL.
module morse_code_decoder_top_tb;
  import mcd_pkg::*;

  // Bytes the package does not name.
  localparam logic [7:0] SymNul = 8'h00;
  localparam logic [7:0] SymLf  = 8'h0A;
  localparam logic [7:0] SymVt  = 8'h0B;
  localparam logic [7:0] SymFf  = 8'h0C;
  localparam logic [7:0] SymTop = 8'hFF;

  localparam int unsigned DirectedCount = 27;
  localparam int unsigned RandomItems   = 1600;
  localparam int unsigned HoldOffCycles = 250;
  localparam int unsigned DrainCycles   = 16;

  // How a directed row is checked: by the predictor, as giving no character, or against a value typed into the table.
  typedef enum logic [1:0] {
    CheckModel,
    CheckSilent,
    CheckChar
  } row_check_e;

  typedef struct packed {
    logic [7:0]       sym;
    logic             eot;
    row_check_e       chk;
    logic [CharW-1:0] ch;
  } directed_row_t;

  // Pending token as the predictor tracks it: symbol count, dash positions and two flags.
  typedef struct packed {
    logic [LenW-1:0]   len;
    logic [MaxLen-1:0] dashes;
    logic              broken;
    logic              lone_slash;
  } token_t;

  // Directed part. Each group of rows exercises one behavior of the decoder; the typed
  // expectations are the ones that are obvious from the rules.
  localparam directed_row_t DirectedRows [DirectedCount] = '{
    // A letter whose final symbol carries end of text, so the flush includes that byte.
    '{SymDot,   1'b0, CheckModel,  7'h00},
    '{SymDash,  1'b1, CheckChar,   7'h41},  // A
    // A lone slash is a word gap and decodes to a space.
    '{SymSlash, 1'b1, CheckChar,   ChSpace},
    // Whitespace with nothing pending gives nothing.
    '{SymSpace, 1'b0, CheckSilent, 7'h00},
    // Whitespace that also carries end of text flushes only once.
    '{SymDot,   1'b0, CheckModel,  7'h00},
    '{SymSpace, 1'b1, CheckChar,   7'h45},  // E
    // Seven symbols: the seventh makes the token too long.
    '{SymDash,  1'b0, CheckModel,  7'h00},
    '{SymDash,  1'b0, CheckModel,  7'h00},
    '{SymDash,  1'b0, CheckModel,  7'h00},
    '{SymDot,   1'b0, CheckModel,  7'h00},
    '{SymDot,   1'b0, CheckModel,  7'h00},
    '{SymDash,  1'b0, CheckModel,  7'h00},
    '{SymDot,   1'b0, CheckModel,  7'h00},
    '{SymLf,    1'b0, CheckSilent, 7'h00},
    // A foreign byte at the top of the range, flushed by end of text.
    '{SymTop,   1'b1, CheckSilent, 7'h00},
    // A slash after a dot spoils the token.
    '{SymDot,   1'b0, CheckModel,  7'h00},
    '{SymSlash, 1'b0, CheckModel,  7'h00},
    '{SymCr,    1'b0, CheckSilent, 7'h00},
    // A dash after a leading slash spoils it as well.
    '{SymSlash, 1'b0, CheckModel,  7'h00},
    '{SymDash,  1'b0, CheckModel,  7'h00},
    '{SymVt,    1'b0, CheckSilent, 7'h00},
    // A well-formed code with no entry in the table.
    '{SymDot,   1'b0, CheckModel,  7'h00},
    '{SymDot,   1'b0, CheckModel,  7'h00},
    '{SymDash,  1'b0, CheckModel,  7'h00},
    '{SymDash,  1'b0, CheckModel,  7'h00},
    '{SymFf,    1'b0, CheckSilent, 7'h00},
    // NUL is a foreign byte too.
    '{SymNul,   1'b1, CheckSilent, 7'h00}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mcd_in_if  in_bus ();
  mcd_out_if out_bus ();

  morse_code_decoder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and the characters still owed by the block, oldest first.
  token_t           token = '0;
  logic [CharW-1:0] text_due [$];
  logic [7:0]       run_bytes [$];

  int unsigned items_sent = 0;
  int unsigned failures   = 0;
  // Both sides idle at random while idle_on is set; it drops for stretches of steady flow.
  logic        idle_on    = 1'b1;
  // Set for one long stretch so that the output backs up and the input has to stall.
  logic        hold_off   = 1'b0;

  // Dot-dash spelling of each character the decoder knows; an empty string for the rest.
  function automatic string morse_of(input logic [7:0] g);
    case (g)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";   "D": return "-..";
      "E": return ".";      "F": return "..-.";   "G": return "--.";    "H": return "....";
      "I": return "..";     "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";    "P": return ".--.";
      "Q": return "--.-";   "R": return ".-.";    "S": return "...";    "T": return "-";
      "U": return "..-";    "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";  "3": return "...--";
      "4": return "....-";  "5": return ".....";  "6": return "-....";  "7": return "--...";
      "8": return "---..";  "9": return "----.";
      "/": return "-..-.";  "?": return "..--.."; ".": return ".-.-.-"; ",": return "--..--";
      "+": return ".-.-.";  "=": return "-...-";
      default: return "";
    endcase
  endfunction

  // Search every known character for one whose spelling gives this length and dash mask.
  function automatic logic morse_match(input logic [LenW-1:0] len,
                                       input logic [MaxLen-1:0] dashes,
                                       output logic [CharW-1:0] ch);
    string             code;
    logic [MaxLen-1:0] mask;
    logic              hit;
    int                g;
    int                j;
    hit = 1'b0;
    ch  = '0;
    for (g = 0; g < 128; g++) begin
      code = morse_of(8'(g));
      if (code.len() != 0 && code.len() == int'(len)) begin
        mask = '0;
        for (j = 0; j < code.len(); j++) begin
          if (code[j] == SymDash) mask[j] = 1'b1;
        end
        if (mask == dashes) begin
          hit = 1'b1;
          ch  = CharW'(g);
        end
      end
    end
    return hit;
  endfunction

  // Decode the pending token, then clear it.
  function automatic logic flush_token(output logic [CharW-1:0] ch);
    logic hit;
    hit = 1'b0;
    ch  = '0;
    if (!token.broken) begin
      if (token.lone_slash) begin
        ch  = ChSpace;
        hit = 1'b1;
      end else if (token.len != 0) begin
        hit = morse_match(token.len, token.dashes, ch);
      end
    end
    token = '0;
    return hit;
  endfunction

  // Take one beat into the predicted token; returns 1 when a character comes out.
  function automatic logic advance_token(input logic [7:0] sym, input logic eot,
                                         output logic [CharW-1:0] ch);
    logic hit;
    logic flushed;
    hit     = 1'b0;
    flushed = 1'b0;
    ch      = '0;
    if (sym == SymSpace || (sym >= SymTab && sym <= SymCr)) begin
      hit     = flush_token(ch);
      flushed = 1'b1;
    end else if (sym == SymDot || sym == SymDash) begin
      if (token.lone_slash || token.len >= LenW'(MaxLen)) begin
        token.broken = 1'b1;
      end else begin
        if (sym == SymDash) token.dashes[token.len] = 1'b1;
        token.len = token.len + 1'b1;
      end
    end else if (sym == SymSlash) begin
      if (token.len == 0 && !token.lone_slash && !token.broken) begin
        token.lone_slash = 1'b1;
      end else begin
        token.broken = 1'b1;
      end
    end else begin
      token.broken = 1'b1;
    end
    if (eot && !flushed) hit = flush_token(ch);
    return hit;
  endfunction

  // Any of the six separator bytes, chosen at random.
  function automatic logic [7:0] pick_separator();
    int unsigned n;
    n = $urandom_range(0, 5);
    return (n == 0) ? SymSpace : SymTab + 8'(n - 1);
  endfunction

  task automatic log_failure(input string what, input string want, input logic [CharW-1:0] got);
    if (failures < 10) $display("%0t: %s: expected %s, got 0x%02h", $time, what, want, got);
    failures++;
  endtask

  // Offer one beat after a random gap, wait for it to be taken, then record what it should
  // produce. Valid stays high between back-to-back beats, so it is never dropped and raised
  // in the same step.
  task automatic send_byte(input logic [7:0] sym, input logic eot, input row_check_e chk,
                           input logic [CharW-1:0] typed);
    int unsigned      gap;
    logic             hit;
    logic [CharW-1:0] ch;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.symbol_char <= sym;
    in_bus.end_of_text <= eot;
    @(posedge clk_i);
    while (!(in_bus.valid && in_bus.ready)) @(posedge clk_i);
    // The predictor always runs so that its token stays in step with the block.
    hit = advance_token(sym, eot, ch);
    case (chk)
      CheckChar:   text_due.push_back(typed);
      CheckSilent: ;
      default: begin
        if (hit) text_due.push_back(ch);
      end
    endcase
    items_sent++;
  endtask

  // Send the bytes gathered in run_bytes, then end the token in one of several ways: end of
  // text on the last byte, a separator with end of text, two separators, or one separator.
  task automatic send_run();
    int unsigned term;
    int          i;
    term = $urandom_range(0, 15);
    for (i = 0; i < run_bytes.size(); i++) begin
      send_byte(run_bytes[i], term == 0 && i == run_bytes.size() - 1, CheckModel, '0);
    end
    if (term != 0) send_byte(pick_separator(), term == 1, CheckModel, '0);
    if (term == 2) send_byte(pick_separator(), 1'b0, CheckModel, '0);
    run_bytes.delete();
  endtask

  // Receiver: ready is set at the falling edge, and results are checked at the rising edge
  // in the order they were predicted. After each result it may hold ready low at random while idle_on is set.
  initial begin
    int unsigned      stall;
    logic [CharW-1:0] want;
    stall = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_bus.ready <= (stall == 0) && !hold_off;
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        if (text_due.size() == 0) begin
          log_failure("character with none pending", "nothing", out_bus.text_char);
        end else begin
          want = text_due.pop_front();
          if (out_bus.text_char !== want) begin
            log_failure("text_char mismatch", $sformatf("0x%02h", want), out_bus.text_char);
          end
        end
        stall = idle_on ? $urandom_range(0, 3) : 0;
      end else if (stall != 0) begin
        stall--;
      end
    end
  end

  // Long hold-off of the receiver while the sender keeps offering beats; the result
  // register fills and the block has to stall its input.
  initial begin
    wait (items_sent >= 400);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Run limit: far above the slowest correct run, with every gap and stall at its longest.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    int          i;
    logic [7:0]  glyph;
    string       code;
    in_bus.valid       <= 1'b0;
    in_bus.symbol_char <= '0;
    in_bus.end_of_text <= 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DirectedCount; i++) begin
      send_byte(DirectedRows[i].sym, DirectedRows[i].eot, DirectedRows[i].chk,
                DirectedRows[i].ch);
    end

    // Random part. Most runs are real Morse characters so that every table entry is hit
    // often; the rest are word gaps, random dot-dash strings (unknown and too-long codes),
    // slash mixes and raw bytes over the whole 8-bit range.
    while (items_sent < DirectedCount + RandomItems) begin
      // One block of 200 beats in every four such blocks runs without any idling on either side.
      idle_on = ((items_sent / 200) % 4) != 3;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        do begin
          glyph = 8'($urandom_range(0, 127));
          code  = morse_of(glyph);
        end while (code.len() == 0);
        for (i = 0; i < code.len(); i++) run_bytes.push_back(code[i]);
      end else if (kind < 70) begin
        run_bytes.push_back(SymSlash);
      end else if (kind < 80) begin
        n = $urandom_range(1, 8);
        repeat (n) run_bytes.push_back($urandom_range(0, 1) ? SymDash : SymDot);
      end else if (kind < 90) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0:       run_bytes.push_back(SymDot);
            1:       run_bytes.push_back(SymDash);
            default: run_bytes.push_back(SymSlash);
          endcase
        end
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) run_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_run();
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    // Let every owed character arrive, then watch a little longer for stray ones.
    while (text_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
